[rtl/core/radial_basis_chebyshev_evaluator_unit_defines.svh]
// Assertion macros shared by the radial basis evaluator RTL
`ifndef RADIAL_BASIS_CHEBYSHEV_EVALUATOR_UNIT_DEFINES_SVH
`define RADIAL_BASIS_CHEBYSHEV_EVALUATOR_UNIT_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define RBCE_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbce: implication check failed");

// antecedent holds -> consequent held in the previous cycle
`define RBCE_ASSERT_AFTER(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> $past(cons)) \
      else $error("rbce: history check failed");

`endif

[rtl/core/rbce_pkg.sv]
// Shared types, constants and helpers for the radial basis evaluator
package rbce_pkg;

   localparam int MaxBasis   = 16;
   localparam int CountLimit = (MaxBasis < 16) ? MaxBasis : 16;
   localparam int IdxW       = 4;
   localparam int ValW       = 48;
   localparam int WideW      = 52;
   localparam int OpW        = 50;
   localparam int HalfW      = 25;
   localparam int PpW        = 2 * HalfW;
   localparam int AccW       = 2 * OpW;
   localparam int CsrIdxW    = 3;
   localparam int CsrDataW   = 32;
   localparam int StepW      = 3;

   // basis modes
   localparam logic [2:0] ModeCutCheb   = 3'd0;
   localparam logic [2:0] ModePlainCheb = 3'd1;
   localparam logic [2:0] ModeTaylor    = 3'd2;
   localparam logic [2:0] ModeCutRep    = 3'd3;
   localparam logic [2:0] ModePlainRep  = 3'd4;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegMode  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegScale = 3'd1;
   localparam logic [CsrIdxW-1:0] RegLower = 3'd2;
   localparam logic [CsrIdxW-1:0] RegUpper = 3'd3;
   localparam logic [CsrIdxW-1:0] RegRecip = 3'd4;
   localparam logic [CsrIdxW-1:0] RegCount = 3'd5;

   localparam logic signed [ValW-1:0] MaxVal = {1'b0, {(ValW-1){1'b1}}};
   localparam logic signed [ValW-1:0] MinVal = {1'b1, {(ValW-1){1'b0}}};
   localparam logic signed [ValW:0]   OneQ24 = 49'sd16777216;

   typedef enum logic [4:0] {
      ST_IDLE, ST_KSI, ST_SD, ST_SQ, ST_Z0,
      ST_C0V, ST_C0G,
      ST_C1T, ST_C1V, ST_C1A, ST_C1B, ST_C1G,
      ST_P1V, ST_P1G,
      ST_RA, ST_RB, ST_RC,
      ST_TG, ST_TV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   start;
      logic signed [OpW-1:0]  a;
      logic signed [OpW-1:0]  b;
   } mul_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic signed [ValW-1:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic signed [ValW-1:0] value;
      logic signed [ValW-1:0] deriv;
   } hist_type;

   // clamp a wide sum into the 48-bit result range
   function automatic logic signed [ValW-1:0] sat48(input logic signed [WideW-1:0] x);
      logic signed [WideW-1:0] hi;
      logic signed [WideW-1:0] lo;
      hi = WideW'(MaxVal);
      lo = WideW'(MinVal);
      if (x > hi) begin
         return MaxVal;
      end else if (x < lo) begin
         return MinVal;
      end else begin
         return x[ValW-1:0];
      end
   endfunction

endpackage

[rtl/core/rbce_mul.sv]
// Shared multi-cycle Q.24 multiplier: 25x25 partial products, rounding, saturation
module rbce_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rbce_pkg::mul_req_type req,
   output rbce_pkg::mul_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rbce_pkg::StepW-1:0]          step_ff, step_in;
   logic                                neg_ff, neg_in;
   logic [rbce_pkg::OpW-1:0]            ma_ff, ma_in;
   logic [rbce_pkg::OpW-1:0]            mb_ff, mb_in;
   logic [rbce_pkg::PpW-1:0]            pp_ff, pp_in;
   logic [1:0]                          sh_ff, sh_in;
   logic [rbce_pkg::AccW-1:0]           acc_ff, acc_in;
   logic signed [rbce_pkg::ValW-1:0]    res_ff, res_in;

   logic [rbce_pkg::HalfW-1:0]          pa, pb;
   logic [rbce_pkg::AccW-1:0]           pp_shifted;
   logic [rbce_pkg::AccW-1:0]           rnd;
   logic [rbce_pkg::AccW-25:0]          q;
   logic                                over;
   logic [rbce_pkg::ValW-1:0]           q48;

   // partial product operand selection
   always_comb begin
      pa = step_ff[1] ? ma_ff[rbce_pkg::OpW-1:rbce_pkg::HalfW] : ma_ff[rbce_pkg::HalfW-1:0];
      pb = step_ff[0] ? mb_ff[rbce_pkg::OpW-1:rbce_pkg::HalfW] : mb_ff[rbce_pkg::HalfW-1:0];
      case (sh_ff)
         2'd0:    pp_shifted = rbce_pkg::AccW'(pp_ff);
         2'd1:    pp_shifted = rbce_pkg::AccW'(pp_ff) << rbce_pkg::HalfW;
         default: pp_shifted = rbce_pkg::AccW'(pp_ff) << (2 * rbce_pkg::HalfW);
      endcase
   end

   // round half away from zero on the magnitude, then saturate
   always_comb begin
      rnd  = acc_ff + rbce_pkg::AccW'(24'h800000);
      q    = rnd[rbce_pkg::AccW-1:24];
      over = neg_ff ? (q > (rbce_pkg::AccW-24)'(rbce_pkg::MaxVal) + 1'b1)
                    : (q > (rbce_pkg::AccW-24)'(rbce_pkg::MaxVal));
      q48  = q[rbce_pkg::ValW-1:0];
   end

   // sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = req.a[rbce_pkg::OpW-1] ^ req.b[rbce_pkg::OpW-1];
         ma_in   = req.a[rbce_pkg::OpW-1] ? rbce_pkg::OpW'(-req.a) : rbce_pkg::OpW'(req.a);
         mb_in   = req.b[rbce_pkg::OpW-1] ? rbce_pkg::OpW'(-req.b) : rbce_pkg::OpW'(req.b);
         acc_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff < 3'd4) begin
            pp_in = pa * pb;
            sh_in = 2'(step_ff[0]) + 2'(step_ff[1]);
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
            acc_in = acc_ff + pp_shifted;
         end
         if (step_ff == 3'd5) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (over) begin
               res_in = neg_ff ? rbce_pkg::MinVal : rbce_pkg::MaxVal;
            end else begin
               res_in = neg_ff ? -$signed(q48) : $signed(q48);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

[rtl/core/rbce_hist_cell.sv]
// One cell of the recurrence history chain: holds a value/derivative pair
module rbce_hist_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  rbce_pkg::hist_type din,
   output rbce_pkg::hist_type dout
);

   rbce_pkg::hist_type held_ff, held_in;

   // take the neighbour's word on each order step
   always_comb begin
      held_in = shift ? din : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign dout = held_ff;

endmodule

[rtl/core/radial_basis_chebyshev_evaluator_unit.sv]
// Top level of the radial basis evaluator: sequencer, datapath and history chain
//
// Usage:
//   req_ channel carries one distance word (unsigned Q7.24). For each one the
//   block sends basis_count (2 to 16) words on rsp_, orders 0..count-1, each
//   with value and derivative (signed Q24.24, saturating); the final one has
//   rsp_last_of_run set. req_stall stays high while a distance is in work.
//   csr_ writes set the mode, scale, cutoffs, 2/(upper-lower) and the count;
//   write them only while the block is idle.
//   All products go through one shared multiplier, one after another.
//   Set-up costs 1 product (plus one more in Taylor or cutoff modes);
//   order 0 costs 0 or 2, order 1 2 to 5, later orders 3 (Chebyshev) or 2
//   (Taylor); each order ends with the hand-over of its word.
//   Reset returns the registers to their defaults, clears the history chain
//   and leaves the block idle. A stalled rsp_ word holds; the sequencer
//   waits at the hand-over step until the output register is free.
`include "radial_basis_chebyshev_evaluator_unit_defines.svh"
module radial_basis_chebyshev_evaluator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [30:0]                         req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rbce_pkg::IdxW-1:0]           rsp_basis_index,
   output logic signed [rbce_pkg::ValW-1:0]    rsp_basis_value,
   output logic signed [rbce_pkg::ValW-1:0]    rsp_basis_derivative,
   output logic                                rsp_last_of_run,
   input  logic                                csr_write_enable,
   input  logic [rbce_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [rbce_pkg::CsrDataW-1:0]       csr_write_data
);

   // configuration registers
   logic [2:0]         mode_ff, mode_in;
   logic signed [31:0] scale_ff, scale_in;
   logic [30:0]        lower_ff, lower_in;
   logic [30:0]        upper_ff, upper_in;
   logic [30:0]        recip_ff, recip_in;
   logic [4:0]         count_ff, count_in;

   // per-distance state
   rbce_pkg::state_type state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [30:0]        d_ff, d_in;
   logic               zero_der_ff, zero_der_in;
   logic               cut_ff, cut_in;
   logic               taylor_ff, taylor_in;
   logic [rbce_pkg::IdxW-1:0] cnt_m1_ff, cnt_m1_in;
   logic [rbce_pkg::IdxW-1:0] ord_ff, ord_in;
   logic signed [rbce_pkg::ValW:0]   ksi_ff, ksi_in;
   logic signed [rbce_pkg::ValW-1:0] sd_ff, sd_in;
   logic signed [rbce_pkg::ValW-1:0] sq_ff, sq_in;
   logic signed [rbce_pkg::ValW-1:0] tmp_ff, tmp_in;
   logic signed [rbce_pkg::ValW-1:0] tmp2_ff, tmp2_in;
   logic signed [rbce_pkg::ValW-1:0] v_ff, v_in;
   logic signed [rbce_pkg::ValW-1:0] g_ff, g_in;
   logic signed [35:0] si_ff, si_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [rbce_pkg::IdxW-1:0] rsp_index_ff, rsp_index_in;
   logic signed [rbce_pkg::ValW-1:0] rsp_value_ff, rsp_value_in;
   logic signed [rbce_pkg::ValW-1:0] rsp_deriv_ff, rsp_deriv_in;
   logic               rsp_last_ff, rsp_last_in;

   rbce_pkg::mul_req_type mul_req;
   rbce_pkg::mul_rsp_type mul_rsp;
   rbce_pkg::hist_type    hist_new, hist_p1, hist_p2;

   logic               accept;
   logic               emit_fire;
   logic               is_mul;
   logic [2:0]         mode_eff;
   logic               rep_sel;
   logic [30:0]        d_sel;
   logic signed [31:0] dlc;
   logic signed [31:0] dm;
   logic signed [rbce_pkg::OpW-1:0] twoksi;
   logic signed [rbce_pkg::WideW-1:0] pair_sum;
   logic signed [rbce_pkg::WideW-1:0] rec_g;
   logic signed [rbce_pkg::WideW-1:0] rec_v;
   logic signed [rbce_pkg::ValW-1:0]  c1_sum;
   rbce_pkg::state_type   order_start;

   assign accept    = req_valid && !req_stall;
   assign emit_fire = (state_ff == rbce_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // mode decode at the input
   always_comb begin
      mode_eff = (mode_ff > rbce_pkg::ModePlainRep) ? rbce_pkg::ModeCutCheb : mode_ff;
      rep_sel  = (mode_eff == rbce_pkg::ModeCutRep) || (mode_eff == rbce_pkg::ModePlainRep);
      d_sel    = (rep_sel && (req_distance < lower_ff)) ? lower_ff : req_distance;
   end

   // derived datapath terms
   always_comb begin
      dlc      = $signed({1'b0, d_ff}) - $signed({1'b0, lower_ff});
      dm       = $signed({1'b0, d_ff}) - $signed({1'b0, upper_ff});
      twoksi   = $signed({ksi_ff, 1'b0});
      pair_sum = rbce_pkg::WideW'(tmp_ff) + rbce_pkg::WideW'(tmp2_ff);
      c1_sum   = rbce_pkg::sat48(pair_sum);
      rec_g    = (pair_sum <<< 1) - rbce_pkg::WideW'(hist_p2.deriv);
      rec_v    = rbce_pkg::WideW'(mul_rsp.result) - rbce_pkg::WideW'(hist_p2.value);
   end

   // first state of the next order
   always_comb begin
      if (ord_ff == '0) begin
         if (cut_ff) begin
            order_start = rbce_pkg::ST_C1T;
         end else if (taylor_ff) begin
            order_start = rbce_pkg::ST_TG;
         end else begin
            order_start = rbce_pkg::ST_P1V;
         end
      end else begin
         order_start = taylor_ff ? rbce_pkg::ST_TG : rbce_pkg::ST_RA;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rbce_pkg::ST_IDLE: if (accept) state_in = rbce_pkg::ST_KSI;
         rbce_pkg::ST_KSI: begin
            if (mul_rsp.done) begin
               if (taylor_ff) begin
                  state_in = rbce_pkg::ST_SD;
               end else if (cut_ff) begin
                  state_in = rbce_pkg::ST_SQ;
               end else begin
                  state_in = rbce_pkg::ST_Z0;
               end
            end
         end
         rbce_pkg::ST_SD:  if (mul_rsp.done) state_in = rbce_pkg::ST_Z0;
         rbce_pkg::ST_SQ:  if (mul_rsp.done) state_in = rbce_pkg::ST_C0V;
         rbce_pkg::ST_Z0:  state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_C0V: if (mul_rsp.done) state_in = rbce_pkg::ST_C0G;
         rbce_pkg::ST_C0G: if (mul_rsp.done) state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_C1T: if (mul_rsp.done) state_in = rbce_pkg::ST_C1V;
         rbce_pkg::ST_C1V: if (mul_rsp.done) state_in = rbce_pkg::ST_C1A;
         rbce_pkg::ST_C1A: if (mul_rsp.done) state_in = rbce_pkg::ST_C1B;
         rbce_pkg::ST_C1B: if (mul_rsp.done) state_in = rbce_pkg::ST_C1G;
         rbce_pkg::ST_C1G: if (mul_rsp.done) state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_P1V: if (mul_rsp.done) state_in = rbce_pkg::ST_P1G;
         rbce_pkg::ST_P1G: if (mul_rsp.done) state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_RA:  if (mul_rsp.done) state_in = rbce_pkg::ST_RB;
         rbce_pkg::ST_RB:  if (mul_rsp.done) state_in = rbce_pkg::ST_RC;
         rbce_pkg::ST_RC:  if (mul_rsp.done) state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_TG:  if (mul_rsp.done) state_in = rbce_pkg::ST_TV;
         rbce_pkg::ST_TV:  if (mul_rsp.done) state_in = rbce_pkg::ST_EMIT;
         rbce_pkg::ST_EMIT: begin
            if (emit_fire) begin
               state_in = (ord_ff == cnt_m1_ff) ? rbce_pkg::ST_IDLE : order_start;
            end
         end
         default: state_in = rbce_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshake and multiplier operands
   always_comb begin
      req_stall = (state_ff != rbce_pkg::ST_IDLE);
      is_mul    = 1'b1;
      mul_req.a = '0;
      mul_req.b = '0;
      unique case (state_ff)
         rbce_pkg::ST_KSI: begin
            mul_req.a = rbce_pkg::OpW'(dlc);
            mul_req.b = $signed({19'b0, recip_ff});
         end
         rbce_pkg::ST_SD: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = $signed({19'b0, d_ff});
         end
         rbce_pkg::ST_SQ: begin
            mul_req.a = rbce_pkg::OpW'(dm);
            mul_req.b = rbce_pkg::OpW'(dm);
         end
         rbce_pkg::ST_C0V: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = rbce_pkg::OpW'(sq_ff);
         end
         rbce_pkg::ST_C0G: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = rbce_pkg::OpW'(dm) <<< 1;
         end
         rbce_pkg::ST_C1T: begin
            mul_req.a = rbce_pkg::OpW'(ksi_ff);
            mul_req.b = rbce_pkg::OpW'(sq_ff);
         end
         rbce_pkg::ST_C1V: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = rbce_pkg::OpW'(tmp_ff);
         end
         rbce_pkg::ST_C1A: begin
            mul_req.a = $signed({19'b0, recip_ff});
            mul_req.b = rbce_pkg::OpW'(sq_ff);
         end
         rbce_pkg::ST_C1B: begin
            mul_req.a = twoksi;
            mul_req.b = rbce_pkg::OpW'(dm);
         end
         rbce_pkg::ST_C1G: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = rbce_pkg::OpW'(c1_sum);
         end
         rbce_pkg::ST_P1V: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = rbce_pkg::OpW'(ksi_ff);
         end
         rbce_pkg::ST_P1G: begin
            mul_req.a = rbce_pkg::OpW'(scale_ff);
            mul_req.b = $signed({19'b0, recip_ff});
         end
         rbce_pkg::ST_RA: begin
            mul_req.a = $signed({19'b0, recip_ff});
            mul_req.b = rbce_pkg::OpW'(hist_p1.value);
         end
         rbce_pkg::ST_RB: begin
            mul_req.a = rbce_pkg::OpW'(ksi_ff);
            mul_req.b = rbce_pkg::OpW'(hist_p1.deriv);
         end
         rbce_pkg::ST_RC: begin
            mul_req.a = twoksi;
            mul_req.b = rbce_pkg::OpW'(hist_p1.value);
         end
         rbce_pkg::ST_TG: begin
            mul_req.a = rbce_pkg::OpW'(si_ff);
            mul_req.b = rbce_pkg::OpW'(hist_p1.value);
         end
         rbce_pkg::ST_TV: begin
            mul_req.a = rbce_pkg::OpW'(sd_ff);
            mul_req.b = rbce_pkg::OpW'(hist_p1.value);
         end
         rbce_pkg::ST_IDLE, rbce_pkg::ST_Z0, rbce_pkg::ST_EMIT: is_mul = 1'b0;
         default: is_mul = 1'b0;
      endcase
      mul_req.start = is_mul && !issued_ff && !mul_rsp.busy && !mul_rsp.done;
      issued_in     = is_mul && !mul_rsp.done && (issued_ff || mul_req.start);
   end

   // configuration writes
   always_comb begin
      mode_in  = mode_ff;
      scale_in = scale_ff;
      lower_in = lower_ff;
      upper_in = upper_ff;
      recip_in = recip_ff;
      count_in = count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rbce_pkg::RegMode:  mode_in  = csr_write_data[2:0];
            rbce_pkg::RegScale: scale_in = $signed(csr_write_data[31:0]);
            rbce_pkg::RegLower: lower_in = csr_write_data[30:0];
            rbce_pkg::RegUpper: upper_in = csr_write_data[30:0];
            rbce_pkg::RegRecip: recip_in = csr_write_data[30:0];
            rbce_pkg::RegCount: count_in = csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // datapath capture
   always_comb begin
      d_in        = d_ff;
      zero_der_in = zero_der_ff;
      cut_in      = cut_ff;
      taylor_in   = taylor_ff;
      cnt_m1_in   = cnt_m1_ff;
      ord_in      = ord_ff;
      ksi_in      = ksi_ff;
      sd_in       = sd_ff;
      sq_in       = sq_ff;
      tmp_in      = tmp_ff;
      tmp2_in     = tmp2_ff;
      v_in        = v_ff;
      g_in        = g_ff;
      si_in       = si_ff;
      if (accept) begin
         d_in        = d_sel;
         zero_der_in = rep_sel && (req_distance <= lower_ff);
         cut_in      = (mode_eff == rbce_pkg::ModeCutCheb) || (mode_eff == rbce_pkg::ModeCutRep);
         taylor_in   = (mode_eff == rbce_pkg::ModeTaylor);
         if (count_ff < 5'd2) begin
            cnt_m1_in = rbce_pkg::IdxW'(1);
         end else if (count_ff > 5'(rbce_pkg::CountLimit)) begin
            cnt_m1_in = rbce_pkg::IdxW'(rbce_pkg::CountLimit - 1);
         end else begin
            cnt_m1_in = rbce_pkg::IdxW'(count_ff - 5'd1);
         end
         ord_in = '0;
         si_in  = '0;
      end
      if (mul_rsp.done) begin
         case (state_ff)
            rbce_pkg::ST_KSI: ksi_in = (rbce_pkg::ValW+1)'(mul_rsp.result) - rbce_pkg::OneQ24;
            rbce_pkg::ST_SD:  sd_in  = mul_rsp.result;
            rbce_pkg::ST_SQ:  sq_in  = mul_rsp.result;
            rbce_pkg::ST_C0V, rbce_pkg::ST_C1V, rbce_pkg::ST_P1V, rbce_pkg::ST_TV:
               v_in = mul_rsp.result;
            rbce_pkg::ST_C0G, rbce_pkg::ST_C1G, rbce_pkg::ST_P1G, rbce_pkg::ST_TG:
               g_in = mul_rsp.result;
            rbce_pkg::ST_C1T, rbce_pkg::ST_C1A, rbce_pkg::ST_RA: tmp_in = mul_rsp.result;
            rbce_pkg::ST_C1B, rbce_pkg::ST_RB: tmp2_in = mul_rsp.result;
            rbce_pkg::ST_RC: begin
               v_in = rbce_pkg::sat48(rec_v);
               g_in = rbce_pkg::sat48(rec_g);
            end
            default: ;
         endcase
      end
      // order zero of plain and Taylor modes is the scale itself
      if (state_ff == rbce_pkg::ST_Z0) begin
         v_in = rbce_pkg::ValW'(scale_ff);
         g_in = '0;
      end
      if (emit_fire) begin
         ord_in = ord_ff + 1'b1;
         si_in  = si_ff + 36'(scale_ff);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_deriv_in = rsp_deriv_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = ord_ff;
         rsp_value_in = v_ff;
         rsp_deriv_in = zero_der_ff ? '0 : g_ff;
         rsp_last_in  = (ord_ff == cnt_m1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rbce_pkg::ModeCutCheb;
         scale_ff     <= 32'sd16777216;
         lower_ff     <= '0;
         upper_ff     <= 31'd83886080;
         recip_ff     <= 31'd6710886;
         count_ff     <= 5'd8;
         state_ff     <= rbce_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         ord_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         scale_ff     <= scale_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         recip_ff     <= recip_in;
         count_ff     <= count_in;
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         ord_ff       <= ord_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff         <= d_in;
      zero_der_ff  <= zero_der_in;
      cut_ff       <= cut_in;
      taylor_ff    <= taylor_in;
      cnt_m1_ff    <= cnt_m1_in;
      ksi_ff       <= ksi_in;
      sd_ff        <= sd_in;
      sq_ff        <= sq_in;
      tmp_ff       <= tmp_in;
      tmp2_ff      <= tmp2_in;
      v_ff         <= v_in;
      g_ff         <= g_in;
      si_ff        <= si_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_deriv_ff <= rsp_deriv_in;
      rsp_last_ff  <= rsp_last_in;
   end

   rbce_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // history chain: newest order enters cell 0, moves on to cell 1
   assign hist_new.value = v_ff;
   assign hist_new.deriv = g_ff;

   rbce_hist_cell u_hist0 (
      .clock (clock),
      .reset (reset),
      .shift (emit_fire),
      .din   (hist_new),
      .dout  (hist_p1)
   );

   rbce_hist_cell u_hist1 (
      .clock (clock),
      .reset (reset),
      .shift (emit_fire),
      .din   (hist_p1),
      .dout  (hist_p2)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_basis_index      = rsp_index_ff;
   assign rsp_basis_value      = rsp_value_ff;
   assign rsp_basis_derivative = rsp_deriv_ff;
   assign rsp_last_of_run      = rsp_last_ff;

   // checks
   `RBCE_ASSERT_IMPLY(a_mul_done_in_mul_state, mul_rsp.done, is_mul)
   `RBCE_ASSERT_IMPLY(a_accept_mul_idle, accept, !mul_rsp.busy && !mul_rsp.done)
   `RBCE_ASSERT_AFTER(a_word_from_emit, $rose(rsp_valid_ff), state_ff == rbce_pkg::ST_EMIT)

endmodule

[test/tb_radial_basis_chebyshev_evaluator_unit.sv]
// Self-checking testbench for the radial basis Chebyshev evaluator unit
module tb_radial_basis_chebyshev_evaluator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Max48  = 64'sd140737488355327;
   localparam longint Min48  = -Max48 - 1;
   localparam longint OneQ   = 64'sd16777216;
   localparam int     Settle = 40;

   typedef struct {
      logic [rbce_pkg::IdxW-1:0]        index;
      logic signed [rbce_pkg::ValW-1:0] value;
      logic signed [rbce_pkg::ValW-1:0] deriv;
      logic                             last;
   } basis_word_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic [30:0]                          req_distance;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [rbce_pkg::IdxW-1:0]            rsp_basis_index;
   logic signed [rbce_pkg::ValW-1:0]     rsp_basis_value;
   logic signed [rbce_pkg::ValW-1:0]     rsp_basis_derivative;
   logic                                 rsp_last_of_run;
   logic                                 csr_write_enable;
   logic [rbce_pkg::CsrIdxW-1:0]         csr_index;
   logic [rbce_pkg::CsrDataW-1:0]        csr_write_data;

   basis_word_type pending_basis[$];
   int          failures;
   int          hold_left;
   bit          quiet;

   // shadow copy of the registers
   logic [2:0]  mode_reg;
   longint      scale_reg;
   longint      lower_reg;
   longint      upper_reg;
   longint      recip_reg;
   logic [4:0]  count_reg;
   // recurrence history
   longint      v_last, v_last2, g_last, g_last2;

   radial_basis_chebyshev_evaluator_unit dut (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic longint clamp48(longint x);
      if (x > Max48) return Max48;
      if (x < Min48) return Min48;
      return x;
   endfunction

   // Q.24 product, round half away from zero, saturate to 48 bits
   function automatic longint mul_q24(longint a, longint b);
      logic         neg;
      logic [63:0]  ua, ub, q, lim;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? 64'(-a) : 64'(a);
      ub  = (b < 0) ? 64'(-b) : 64'(b);
      p   = {64'd0, ua} * {64'd0, ub};
      p   = p + 128'h800000;
      if (p[127:88] != 0) return neg ? Min48 : Max48;
      q   = p[87:24];
      lim = neg ? 64'(Max48) + 64'd1 : 64'(Max48);
      if (q > lim) return neg ? Min48 : Max48;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // work out every basis word one distance gives
   task automatic predict_basis(input logic [30:0] distance);
      logic [2:0] mode;
      bit         rep, cut, zero_der;
      int         count;
      longint     d, dm, sq, ksi, twoksi, mult, sd, v, g, t;
      basis_word_type w;
      mode = (mode_reg > rbce_pkg::ModePlainRep) ? rbce_pkg::ModeCutCheb : mode_reg;
      rep  = (mode == rbce_pkg::ModeCutRep) || (mode == rbce_pkg::ModePlainRep);
      cut  = (mode == rbce_pkg::ModeCutCheb) || (mode == rbce_pkg::ModeCutRep);
      count = count_reg;
      if (count < 2) count = 2;
      if (count > 16) count = 16;
      d = longint'(distance);
      zero_der = 0;
      if (rep) begin
         if (d <= lower_reg) zero_der = 1;
         if (d < lower_reg) d = lower_reg;
      end
      mult   = recip_reg;
      ksi    = mul_q24(d - lower_reg, mult) - OneQ;
      twoksi = 2 * ksi;
      sd     = mul_q24(scale_reg, d);
      dm     = d - upper_reg;
      sq     = mul_q24(dm, dm);
      for (int i = 0; i < count; i++) begin
         if (mode == rbce_pkg::ModeTaylor) begin
            if (i == 0) begin
               v = scale_reg;
               g = 0;
            end else begin
               g = mul_q24(scale_reg * i, v_last);
               v = mul_q24(sd, v_last);
            end
         end else if (i == 0) begin
            v = cut ? mul_q24(scale_reg, sq) : scale_reg;
            g = cut ? mul_q24(scale_reg, 2 * dm) : 0;
         end else if (i == 1) begin
            if (cut) begin
               v = mul_q24(scale_reg, mul_q24(ksi, sq));
               g = mul_q24(scale_reg, clamp48(mul_q24(mult, sq) + mul_q24(twoksi, dm)));
            end else begin
               v = mul_q24(scale_reg, ksi);
               g = mul_q24(scale_reg, mult);
            end
         end else begin
            t = mul_q24(mult, v_last) + mul_q24(ksi, g_last);
            g = clamp48(2 * t - g_last2);
            v = clamp48(mul_q24(twoksi, v_last) - v_last2);
         end
         v_last2 = v_last;
         v_last  = v;
         g_last2 = g_last;
         g_last  = g;
         w.index = i[rbce_pkg::IdxW-1:0];
         w.value = v[rbce_pkg::ValW-1:0];
         w.deriv = zero_der ? '0 : g[rbce_pkg::ValW-1:0];
         w.last  = (i + 1 == count);
         pending_basis.push_back(w);
      end
   endtask

   // offer one distance word and wait for it to be taken
   task automatic send_distance(input logic [30:0] distance);
      if (!quiet && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_distance <= distance;
      do @(posedge clock); while (req_stall);
      predict_basis(distance);
   endtask

   // stop offering and let every expected word arrive
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_basis.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   // one register write, with the enable dropped again after it
   task automatic write_reg(input logic [rbce_pkg::CsrIdxW-1:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         rbce_pkg::RegMode:  mode_reg  = data[2:0];
         rbce_pkg::RegScale: scale_reg = longint'($signed(data));
         rbce_pkg::RegLower: lower_reg = longint'(data[30:0]);
         rbce_pkg::RegUpper: upper_reg = longint'(data[30:0]);
         rbce_pkg::RegRecip: recip_reg = longint'(data[30:0]);
         rbce_pkg::RegCount: count_reg = data[4:0];
         default: ;
      endcase
   endtask

   task automatic set_all(input logic [2:0] m, input logic [31:0] s, input logic [30:0] lo,
                          input logic [30:0] hi, input logic [30:0] r, input logic [4:0] n);
      write_reg(rbce_pkg::RegMode, 32'(m));
      write_reg(rbce_pkg::RegScale, s);
      write_reg(rbce_pkg::RegLower, 32'(lo));
      write_reg(rbce_pkg::RegUpper, 32'(hi));
      write_reg(rbce_pkg::RegRecip, 32'(r));
      write_reg(rbce_pkg::RegCount, 32'(n));
   endtask

   function automatic logic [30:0] rand_distance();
      if ($urandom_range(0, 3) == 0) return 31'($urandom());
      return 31'($urandom_range(0, 32'h0A00_0000));
   endfunction

   // extremes of the distance, every mode, clamp cases, count limits
   task automatic test_directed();
      set_all(rbce_pkg::ModeCutCheb, 32'h0100_0000, 31'd0, 31'h0500_0000, 31'd6710886, 5'd4);
      send_distance(31'd0);
      send_distance(31'h7FFF_FFFF);
      send_distance(31'h0280_0000);
      wait_drained();
      for (int m = 1; m <= 7; m++) begin
         write_reg(rbce_pkg::RegMode, 32'(m));
         send_distance(31'h0180_0000);
         send_distance(31'h7FFF_FFFF);
         wait_drained();
      end
      // repulsive clamp below, at and above the lower cutoff
      set_all(rbce_pkg::ModeCutRep, 32'h0100_0000, 31'h0100_0000, 31'h0500_0000,
              31'h0080_0000, 5'd3);
      send_distance(31'h0080_0000);
      send_distance(31'h0100_0000);
      send_distance(31'h0100_0001);
      wait_drained();
      // count below two and above the limit
      write_reg(rbce_pkg::RegCount, 32'd0);
      send_distance(31'h0200_0000);
      wait_drained();
      write_reg(rbce_pkg::RegCount, 32'd1);
      send_distance(31'h0200_0000);
      wait_drained();
      write_reg(rbce_pkg::RegCount, 32'd31);
      send_distance(31'h0200_0000);
      wait_drained();
      // degenerate cutoffs and extreme scale and reciprocal
      set_all(rbce_pkg::ModePlainCheb, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF,
              5'd16);
      send_distance(31'h0300_0000);
      wait_drained();
      set_all(rbce_pkg::ModeTaylor, 32'h7FFF_FFFF, 31'd0, 31'd0, 31'd0, 5'd17);
      send_distance(31'h7FFF_FFFF);
      wait_drained();
   endtask

   // random register settings, each with a batch of random distances
   task automatic test_random();
      logic [31:0] s;
      for (int phase = 0; phase < 10; phase++) begin
         quiet = (phase == 4);
         s = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 32'h0200_0000));
         if ($urandom_range(0, 1)) s = -s;
         set_all(3'($urandom_range(0, 7)), s, 31'($urandom_range(0, 32'h0200_0000)),
                 31'($urandom_range(0, 32'h0A00_0000)),
                 ($urandom_range(0, 4) == 0) ? 31'($urandom()) :
                                               31'($urandom_range(0, 32'h0200_0000)),
                 ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 8)));
         for (int k = 0; k < 27; k++) send_distance(rand_distance());
         wait_drained();
      end
      quiet = 0;
   endtask

   // receiver holds off for a long stretch while distances keep coming
   task automatic test_backpressure();
      set_all(rbce_pkg::ModePlainCheb, 32'h0100_0000, 31'd0, 31'h0500_0000, 31'd6710886, 5'd6);
      quiet     = 1;
      hold_left = 600;
      for (int k = 0; k < 6; k++) send_distance(rand_distance());
      quiet = 0;
      wait_drained();
   endtask

   // sender pauses until every word is back, then sends again
   task automatic test_drain_pause();
      write_reg(rbce_pkg::RegMode, 32'(rbce_pkg::ModeCutCheb));
      send_distance(31'h0100_0000);
      send_distance(31'h0200_0000);
      req_valid <= 1'b0;
      while (pending_basis.size() != 0) @(posedge clock);
      send_distance(31'h0300_0000);
      wait_drained();
   endtask

   // receiver stall, with a counted long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left  = hold_left - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 9);
      end
   end

   // compare each taken word with the oldest expected one
   always @(posedge clock) begin
      basis_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_basis.size() == 0) begin
            $error("unexpected word: index %0d", rsp_basis_index);
            failures++;
         end else begin
            w = pending_basis.pop_front();
            if (rsp_basis_index !== w.index) begin
               $error("basis_index exp %0d got %0d", w.index, rsp_basis_index);
               failures++;
            end
            if (rsp_basis_value !== w.value) begin
               $error("basis_value exp %0d got %0d", w.value, rsp_basis_value);
               failures++;
            end
            if (rsp_basis_derivative !== w.deriv) begin
               $error("basis_derivative exp %0d got %0d", w.deriv, rsp_basis_derivative);
               failures++;
            end
            if (rsp_last_of_run !== w.last) begin
               $error("last_of_run exp %0b got %0b", w.last, rsp_last_of_run);
               failures++;
            end
         end
      end
   end

   initial begin
      failures = 0;
      hold_left = 0;
      quiet = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_distance = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mode_reg = rbce_pkg::ModeCutCheb;
      scale_reg = 16777216;
      lower_reg = 0;
      upper_reg = 83886080;
      recip_reg = 6710886;
      count_reg = 5'd8;
      v_last = 0;
      v_last2 = 0;
      g_last = 0;
      g_last2 = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      // reset defaults first, before any write
      send_distance(31'h0180_0000);
      wait_drained();
      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random();
      wait_drained();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
